[design/bmhq_pkg.sv]
// bmhq_pkg: operation and status codes, result struct and sequencer states
// for the binary max heap queue. No dependencies.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int DATA_W = 32;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_PEEK   = 2'd1;
  localparam kind_t KIND_POP    = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   top_value;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_WAIT,
    ST_LAST_WAIT,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_FIN
  } seq_state_t;

endpackage

[design/bmhq_if.sv]
// bmhq_req_if / bmhq_rsp_if: valid/ready channels of the heap queue.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps

interface bmhq_req_if;
  import bmhq_pkg::*;
  logic              valid;
  logic              ready;
  kind_t             kind;
  logic [DATA_W-1:0] item_value;
  modport source (output valid, output kind, output item_value, input ready);
  modport sink (input valid, input kind, input item_value, output ready);
endinterface

interface bmhq_rsp_if;
  import bmhq_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [DATA_W-1:0] top_value;
  modport source (output valid, output status, output top_value, input ready);
  modport sink (input valid, input status, input top_value, output ready);
endinterface

[design/bmhq_ram.sv]
// bmhq_ram: heap storage, one write port and one registered read port.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [bmhq_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [bmhq_pkg::DATA_W-1:0] rdata
);
  import bmhq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/bmhq_seq.sv]
// bmhq_seq: heap sequencer with one shared comparator; runs sift up and
// sift down one level at a time through bmhq_ram. Depends on bmhq_pkg.
`timescale 1ns / 1ps

module bmhq_seq #(
  parameter int CAPACITY = 1024,
  localparam int PW = $clog2(CAPACITY + 1),
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  bmhq_pkg::kind_t             req_kind,
  input  logic [bmhq_pkg::DATA_W-1:0] req_value,
  output logic                        req_ready,
  output logic                        res_valid,
  output bmhq_pkg::res_t              res,
  input  logic                        res_take,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [bmhq_pkg::DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [bmhq_pkg::DATA_W-1:0] ram_rdata
);
  import bmhq_pkg::*;

  seq_state_t        state, state_next;
  kind_t             kind, kind_next;
  status_t           status, status_next;
  logic [DATA_W-1:0] top, top_next;
  logic [DATA_W-1:0] cur, cur_next;
  logic [DATA_W-1:0] bestv, bestv_next;
  logic              sel_left, sel_left_next;
  logic [PW-1:0]     pos, pos_next;
  logic [PW-1:0]     count, count_next;

  logic [DATA_W-1:0] cmp_a, cmp_b;
  logic              gt;
  logic [PW-1:0]     pos_m1, parent, parent_m1, count_m1;
  logic [PW:0]       left, right, left_m1, right_m1;
  logic              right_ok;

  assign gt        = cmp_a > cmp_b;
  assign pos_m1    = pos - PW'(1);
  assign parent    = pos >> 1;
  assign parent_m1 = parent - PW'(1);
  assign count_m1  = count - PW'(1);
  assign left      = {pos, 1'b0};
  assign right     = {pos, 1'b1};
  assign left_m1   = left - (PW+1)'(1);
  assign right_m1  = left;
  assign right_ok  = right <= {1'b0, count};

  assign req_ready     = state == ST_IDLE;
  assign res.status    = status;
  assign res.top_value = top;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    status   <= status_next;
    top      <= top_next;
    cur      <= cur_next;
    bestv    <= bestv_next;
    sel_left <= sel_left_next;
    pos      <= pos_next;
  end

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    status_next   = status;
    top_next      = top;
    cur_next      = cur;
    bestv_next    = bestv;
    sel_left_next = sel_left;
    pos_next      = pos;
    count_next    = count;
    ram_we        = 1'b0;
    ram_waddr     = pos_m1[AW-1:0];
    ram_wdata     = cur;
    ram_raddr     = '0;
    cmp_a         = ram_rdata;
    cmp_b         = cur;
    res_valid     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          kind_next   = req_kind;
          status_next = STATUS_OK;
          top_next    = '0;
          case (req_kind)
            KIND_INSERT: begin
              if (count == PW'(CAPACITY)) begin
                status_next = STATUS_FULL;
                state_next  = ST_FIN;
              end else begin
                pos_next   = count + PW'(1);
                count_next = count + PW'(1);
                cur_next   = req_value;
                state_next = ST_UP_RD;
              end
            end
            KIND_PEEK, KIND_POP: begin
              if (count == '0) begin
                status_next = STATUS_EMPTY;
                state_next  = ST_FIN;
              end else begin
                state_next = ST_ROOT_RD;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos == PW'(1)) begin
          ram_we     = 1'b1;
          state_next = ST_FIN;
        end else begin
          ram_raddr  = parent_m1[AW-1:0];
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmp_a = cur;
        cmp_b = ram_rdata;
        ram_we = 1'b1;
        if (gt) begin
          ram_wdata  = ram_rdata;
          pos_next   = parent;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_ROOT_RD: begin
        ram_raddr  = '0;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        top_next = ram_rdata;
        if (kind == KIND_POP) begin
          ram_raddr  = count_m1[AW-1:0];
          state_next = ST_LAST_WAIT;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_LAST_WAIT: begin
        cur_next   = ram_rdata;
        count_next = count_m1;
        pos_next   = PW'(1);
        if (count == PW'(1)) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_DN_RDL;
        end
      end
      ST_DN_RDL: begin
        if (left > {1'b0, count}) begin
          ram_we     = 1'b1;
          state_next = ST_FIN;
        end else begin
          ram_raddr  = left_m1[AW-1:0];
          state_next = ST_DN_RDR;
        end
      end
      ST_DN_RDR: begin
        cmp_a = ram_rdata;
        cmp_b = cur;
        if (gt) begin
          bestv_next    = ram_rdata;
          sel_left_next = 1'b1;
        end else begin
          bestv_next    = cur;
          sel_left_next = 1'b0;
        end
        if (right_ok) begin
          ram_raddr = right_m1[AW-1:0];
        end
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmp_a  = ram_rdata;
        cmp_b  = bestv;
        ram_we = 1'b1;
        if (right_ok && gt) begin
          ram_wdata  = ram_rdata;
          pos_next   = right[PW-1:0];
          state_next = ST_DN_RDL;
        end else if (sel_left) begin
          ram_wdata  = bestv;
          pos_next   = left[PW-1:0];
          state_next = ST_DN_RDL;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[design/binary_max_heap_queue.sv]
// binary_max_heap_queue: max-priority queue on a 1-indexed binary heap.
// Depends on bmhq_pkg, bmhq_if, bmhq_ram and bmhq_seq.
//
//   channel  dir  transfer payload          notes
//   req      in   kind, item_value          0 insert, 1 peek, 2 pop
//   rsp      out  status, top_value         one response per request
//
// insert climbs one level per parent read and compare; peek reads the root;
// pop reads the root and last item and, if any remain, sifts down a level
// per child read and compare; one memory read per cycle on the single read port
// rst is synchronous and clears the count; memory contents need no clearing
// req is taken only between operations; a held response in the output register
// does not block the next request, a second one waits in the sequencer
`timescale 1ns / 1ps

module binary_max_heap_queue #(
  parameter int CAPACITY = 1024
) (
  input logic        clk,
  input logic        rst,
  bmhq_req_if.sink   req,
  bmhq_rsp_if.source rsp
);
  import bmhq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic              res_valid, res_take;
  res_t              res;
  logic              out_valid;
  res_t              out_res;

  bmhq_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmhq_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_value (req.item_value),
    .req_ready (req.ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register, loads when empty or drained in the same cycle
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_res.status;
  assign rsp.top_value = out_res.top_value;

endmodule

[verif/tb_top.sv]
// tb_top: self-checking bench for binary_max_heap_queue; a heap predictor in a
// scoreboard class checks every response in order. Depends on bmhq_pkg, bmhq_if.
`timescale 1ns / 1ps

import bmhq_pkg::*;

class heap_scoreboard #(int unsigned DEPTH = 1024);
  logic [DATA_W-1:0] slots [1:DEPTH];
  int unsigned count;
  res_t pending_q[$];
  int errors;

  function new();
    count = 0;
    errors = 0;
  endfunction

  function void swap_slots(int unsigned a, int unsigned b);
    logic [DATA_W-1:0] t;
    t = slots[a];
    slots[a] = slots[b];
    slots[b] = t;
  endfunction

  function void sift_up(int unsigned start);
    int unsigned pos;
    pos = start;
    while (pos > 1 && slots[pos] > slots[pos >> 1]) begin
      swap_slots(pos, pos >> 1);
      pos = pos >> 1;
    end
  endfunction

  function void sift_down();
    int unsigned pos;
    int unsigned best;
    int unsigned lft;
    pos = 1;
    while (1'b1) begin
      best = pos;
      lft = pos * 2;
      if (lft <= count && slots[lft] > slots[best]) best = lft;
      if (lft + 1 <= count && slots[lft + 1] > slots[best]) best = lft + 1;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function void note_request(kind_t kind, logic [DATA_W-1:0] value);
    res_t exp_res;
    exp_res.status = STATUS_OK;
    exp_res.top_value = '0;
    if (kind == KIND_INSERT) begin
      if (count >= DEPTH) begin
        exp_res.status = STATUS_FULL;
      end else begin
        count++;
        slots[count] = value;
        sift_up(count);
      end
    end else if (kind == KIND_PEEK || kind == KIND_POP) begin
      if (count == 0) begin
        exp_res.status = STATUS_EMPTY;
      end else begin
        exp_res.top_value = slots[1];
        if (kind == KIND_POP) begin
          slots[1] = slots[count];
          count--;
          sift_down();
        end
      end
    end
    pending_q.push_back(exp_res);
  endfunction

  task report(string msg);
    $display("[%0t] error: %s", $time, msg);
    errors++;
  endtask

  task check_response(status_t status, logic [DATA_W-1:0] top_value);
    res_t exp_res;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected response status=%0d top=%08h", status, top_value));
    end else begin
      exp_res = pending_q.pop_front();
      if (status !== exp_res.status)
        report($sformatf("status %0d, want %0d", status, exp_res.status));
      if (top_value !== exp_res.top_value)
        report($sformatf("top_value %08h, want %08h", top_value, exp_res.top_value));
    end
  endtask
endclass

module tb_top;
  localparam int CAPACITY = 1024;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;

  logic clk;
  logic rst;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;
  heap_scoreboard #(CAPACITY) sb;

  bmhq_req_if req_ch ();
  bmhq_rsp_if rsp_ch ();

  binary_max_heap_queue #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.status, rsp_ch.top_value);
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.kind, req_ch.item_value);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task send_op(kind_t kind, logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.item_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task wait_all_responses();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  function logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(15);
    if (r < 40) begin
      case ($urandom_range(3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function kind_t pick_kind(int ins_w, int peek_w, int pop_w);
    int r;
    r = $urandom_range(99);
    if (r < ins_w) return KIND_INSERT;
    if (r < ins_w + peek_w) return KIND_PEEK;
    if (r < ins_w + peek_w + pop_w) return KIND_POP;
    return KIND_UNUSED;
  endfunction

  task run_mix(int items, int ins_w, int peek_w, int pop_w);
    repeat (items) send_op(pick_kind(ins_w, peek_w, pop_w), pick_value());
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    stall_cycles = 0;
    send_idle_pct = 35;
    recv_idle_pct = 85;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_INSERT;
    req_ch.item_value = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty, unused kind, extremes and equal keys
    send_op(KIND_POP, 32'h1234_5678);
    send_op(KIND_PEEK, 32'hFFFF_FFFF);
    send_op(KIND_UNUSED, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0000);
    send_op(KIND_PEEK, 32'h0);
    send_op(KIND_INSERT, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0007);
    send_op(KIND_INSERT, 32'h0000_0007);
    send_op(KIND_INSERT, 32'h8000_0000);
    send_op(KIND_INSERT, 32'h7FFF_FFFF);
    send_op(KIND_INSERT, 32'hFFFF_FFFF);
    send_op(KIND_UNUSED, 32'hAAAA_5555);
    send_op(KIND_PEEK, 32'h0);
    repeat (7) send_op(KIND_POP, 32'h0);
    send_op(KIND_PEEK, 32'h0);
    wait_all_responses();

    run_mix(300, 60, 12, 25);
    wait_all_responses();

    send_idle_pct = 85;
    recv_idle_pct = 35;
    while (sb.count < CAPACITY) begin
      if ($urandom_range(9) == 0) send_op(KIND_PEEK, pick_value());
      else send_op(KIND_INSERT, pick_value());
    end
    repeat (6) send_op(KIND_INSERT, pick_value());
    send_op(KIND_PEEK, 32'h0);
    wait_all_responses();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mix(350, 15, 12, 70);
    wait_all_responses();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
